// ----- rtl/outlier_rejecting_window_average_macros.svh -----
// Assertion macros shared by the outlier-rejecting window average RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef OUTLIER_REJECTING_WINDOW_AVERAGE_MACROS_SVH
`define OUTLIER_REJECTING_WINDOW_AVERAGE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ORWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orwa: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define ORWA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orwa: same-cycle check failed");

`endif

// ----- rtl/orwa_pkg.sv -----
// Shared constants, types and controller/datapath command structs.
// No dependencies; the interfaces and every module import this package.
package orwa_pkg;

    localparam int WINDOW_LENGTH = 5;
    localparam int SAMPLE_W      = 21;
    localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W         = SAMPLE_W + CNT_W;
    localparam int DSQ_W         = 2 * SUM_W;
    localparam int SPREAD_W      = DSQ_W + CNT_W;
    localparam int WIN_IDX_W     = $clog2(WINDOW_LENGTH);
    localparam int STEP_W        = $clog2(SUM_W);
    localparam int KEPT_OUT_W    = 3;
    localparam int KEPT_MAX      = 7;
    localparam int CFG_IDX_W     = 1;

    localparam logic [SAMPLE_W-1:0] LOWER_RESET = SAMPLE_W'(700000);
    localparam logic [SAMPLE_W-1:0] UPPER_RESET = SAMPLE_W'(1100000);

    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = CFG_IDX_W'(1);

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [KEPT_OUT_W-1:0] kept_out_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [STEP_W-1:0]     step_t;

    typedef struct packed {
        logic  shift;
        logic  clear;
        logic  sum_en;
        logic  issue;
        logic  spread_en;
        logic  keep_en;
        logic  div_step;
        logic  out_load;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic kept_zero;
    } dp_sts_t;

endpackage

// ----- rtl/orwa_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on orwa_pkg for the payload types.
interface orwa_in_if;
    import orwa_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface orwa_out_if;
    import orwa_pkg::*;

    logic      valid;
    logic      ready;
    sample_t   filtered_pressure;
    logic      valid_res;
    kept_out_t kept_count;

    modport source (output valid, output filtered_pressure, output valid_res,
                    output kept_count, input ready);
    modport sink (input valid, input filtered_pressure, input valid_res,
                  input kept_count, output ready);
endinterface

// ----- rtl/orwa_ctrl.sv -----
// Sequencing state machine: sum, spread, keep, divide and output phases.
// Depends on orwa_pkg and the assertion macro header.
`include "outlier_rejecting_window_average_macros.svh"

module orwa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  orwa_pkg::dp_sts_t sts,
    output orwa_pkg::dp_cmd_t cmd
);
    import orwa_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SUM    = 6'b000010,
        ST_SPREAD = 6'b000100,
        ST_KEEP   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam step_t SUM_LAST  = STEP_W'(WINDOW_LENGTH - 1);
    localparam step_t PIPE_LAST = STEP_W'(WINDOW_LENGTH + 1);
    localparam step_t DIV_LAST  = STEP_W'(SUM_W - 1);
    localparam step_t WIN_END   = STEP_W'(WINDOW_LENGTH);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.shift  = 1'b1;
                    cmd.clear  = 1'b1;
                    step_next  = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == SUM_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_SPREAD;
                end
            end
            ST_SPREAD:
            begin
                cmd.issue     = (step_reg < WIN_END);
                cmd.spread_en = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == PIPE_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_KEEP;
                end
            end
            ST_KEEP:
            begin
                cmd.issue   = (step_reg < WIN_END);
                cmd.keep_en = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == PIPE_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.kept_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    step_next    = step_reg + 1'b1;
                    if (step_reg == DIV_LAST)
                    begin
                        step_next  = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ORWA_ASSERT_NEXT(a_accept_starts_sum, clk, rst_n, in_fire,
        (state_reg == ST_SUM) && (step_reg == '0))
    `ORWA_ASSERT_SAME(a_sum_step_bound, clk, rst_n, (state_reg == ST_SUM),
        (step_reg <= SUM_LAST))
    `ORWA_ASSERT_NEXT(a_div_ends_done, clk, rst_n,
        (state_reg == ST_DIV) && !sts.kept_zero && (step_reg == DIV_LAST),
        (state_reg == ST_DONE))
    `ORWA_ASSERT_NEXT(a_done_free_loads, clk, rst_n,
        (state_reg == ST_DONE) && !out_valid_reg,
        out_valid_reg && (state_reg == ST_IDLE))

endmodule

// ----- rtl/orwa_dp.sv -----
// Datapath: limit registers, sample window, deviation pipeline, accumulators,
// radix-2 divider and output register. Depends on orwa_pkg.
module orwa_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  orwa_pkg::cfg_idx_t  cfg_index,
    input  orwa_pkg::sample_t   cfg_data,
    input  orwa_pkg::sample_t   sample,
    input  orwa_pkg::dp_cmd_t   cmd,
    output orwa_pkg::dp_sts_t   sts,
    output orwa_pkg::sample_t   filtered_pressure,
    output logic                valid_res,
    output orwa_pkg::kept_out_t kept_count
);
    import orwa_pkg::*;

    localparam step_t                WIN_END    = STEP_W'(WINDOW_LENGTH);
    localparam logic [SUM_W-1:0]     LEN_SUM    = SUM_W'(WINDOW_LENGTH);
    localparam logic [SPREAD_W-1:0]  LEN_M1     = SPREAD_W'(WINDOW_LENGTH - 1);
    localparam logic [CNT_W+2:0]     KEPT_LIMIT = (CNT_W + 3)'(KEPT_MAX);

    sample_t              lower_reg;
    sample_t              upper_reg;
    sample_t              win_reg [WINDOW_LENGTH];

    logic [SUM_W-1:0]     sum_reg;
    logic [SPREAD_W-1:0]  spread_reg;
    logic [SUM_W-1:0]     kept_sum_reg;
    logic [CNT_W-1:0]     kept_reg;
    logic [CNT_W-1:0]     rem_reg;

    logic                 v1_reg, v2_reg;
    logic                 ok1_reg, ok2_reg;
    sample_t              p1_reg, p2_reg;
    logic [SUM_W-1:0]     d_reg;
    logic [DSQ_W-1:0]     dsq_reg;

    sample_t              out_p_reg;
    logic                 out_v_reg;
    kept_out_t            out_k_reg;

    sample_t              rd_sample;
    logic [WIN_IDX_W-1:0] rd_idx;
    logic                 rd_ok;
    logic [SUM_W-1:0]     lp;
    logic [SUM_W-1:0]     d_next;
    logic [SPREAD_W-1:0]  scaled;
    logic                 keep_hit;
    logic [CNT_W:0]       rem_shift;
    logic [CNT_W:0]       rem_diff;
    logic                 q_bit;
    kept_out_t            kept_sat;

    function automatic logic plausible(input sample_t p, input sample_t lo,
                                       input sample_t hi);
        return (p > lo) && (p < hi);
    endfunction

    assign rd_idx    = cmd.step[WIN_IDX_W-1:0];
    assign rd_sample = (cmd.step < WIN_END) ? win_reg[rd_idx] : '0;
    assign rd_ok     = plausible(rd_sample, lower_reg, upper_reg);

    assign lp     = SUM_W'(rd_sample) * LEN_SUM;
    assign d_next = (lp >= sum_reg) ? (lp - sum_reg) : (sum_reg - lp);

    assign scaled   = SPREAD_W'(dsq_reg) * LEN_M1;
    assign keep_hit = v2_reg && ok2_reg && (scaled <= spread_reg);

    assign rem_shift = {rem_reg, kept_sum_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, kept_reg};
    assign q_bit     = (rem_shift >= {1'b0, kept_reg});

    assign kept_sat = ((CNT_W + 3)'(kept_reg) > KEPT_LIMIT) ? KEPT_OUT_W'(KEPT_MAX)
                                                           : KEPT_OUT_W'(kept_reg);

    assign sts.kept_zero = (kept_reg == '0);

    assign filtered_pressure = out_p_reg;
    assign valid_res         = out_v_reg;
    assign kept_count        = out_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                win_reg[i] <= '0;
            end
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOWER_LIMIT: lower_reg <= cfg_data;
                    REG_UPPER_LIMIT: upper_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.shift)
            begin
                win_reg[0] <= sample;
                for (int i = 1; i < WINDOW_LENGTH; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= rd_sample;
        ok1_reg <= rd_ok;
        d_reg   <= d_next;
        p2_reg  <= p1_reg;
        ok2_reg <= ok1_reg;
        dsq_reg <= DSQ_W'(d_reg) * DSQ_W'(d_reg);

        if (cmd.clear)
        begin
            sum_reg      <= '0;
            spread_reg   <= '0;
            kept_sum_reg <= '0;
            kept_reg     <= '0;
            rem_reg      <= '0;
        end
        else
        begin
            if (cmd.sum_en && rd_ok)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_sample);
            end
            if (cmd.spread_en && v2_reg && ok2_reg)
            begin
                spread_reg <= spread_reg + SPREAD_W'(dsq_reg);
            end
            if (cmd.keep_en && keep_hit)
            begin
                kept_sum_reg <= kept_sum_reg + SUM_W'(p2_reg);
                kept_reg     <= kept_reg + 1'b1;
            end
            if (cmd.div_step)
            begin
                rem_reg      <= q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                kept_sum_reg <= {kept_sum_reg[SUM_W-2:0], q_bit};
            end
        end

        if (cmd.out_load)
        begin
            out_p_reg <= sts.kept_zero ? '0 : kept_sum_reg[SAMPLE_W-1:0];
            out_v_reg <= !sts.kept_zero;
            out_k_reg <= kept_sat;
        end
    end

endmodule

// ----- rtl/outlier_rejecting_window_average.sv -----
// Top level of the outlier-rejecting window average of pressure samples.
// Depends on orwa_pkg, orwa_if, orwa_ctrl and orwa_dp.
//
// Use: each item on the samples channel carries one 21-bit pressure sample in
// tenths of a pascal. It is shifted into a window of the last five samples,
// and one result item follows on the results channel: the truncated average
// of the plausible samples within one standard deviation of the mean, a flag
// that some sample was kept, and the number kept.
// One item is processed at a time. After the accepting edge the datapath
// runs a sum pass over the window, a deviation pass and a keep pass
// through the squaring pipeline, a radix-2 divider (skipped when nothing
// is kept) and a load of the output register. If the receiver stalls,
// the finished result waits in the output register while the next item
// is accepted and computed; that item then holds until the register is
// taken. Reset empties the output, zeroes the window and loads the limits
// with 700000 and 1100000. The user must write the limits through cfg_we,
// cfg_index and cfg_data only while no item is in flight; the block itself
// does not enforce this.
module outlier_rejecting_window_average (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  orwa_pkg::cfg_idx_t cfg_index,
    input  orwa_pkg::sample_t  cfg_data,
    orwa_in_if.sink            samples,
    orwa_out_if.source         results
);
    import orwa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    orwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    orwa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample            (samples.sample),
        .cmd               (cmd),
        .sts               (sts),
        .filtered_pressure (results.filtered_pressure),
        .valid_res         (results.valid_res),
        .kept_count        (results.kept_count)
    );

endmodule
